// ----- rtl/icf_pkg.sv -----
`timescale 1ns / 1ps

package icf_pkg;

  localparam int unsigned PixW        = 8;
  localparam int unsigned CoefW       = 16;
  localparam int unsigned SizeW       = 11;
  localparam int unsigned ProdW       = 25;
  localparam int unsigned FiltW       = 26;
  localparam int unsigned RowW        = 10;
  localparam int unsigned HeightLimit = 1024;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_COEF_TL   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_COEF_TR   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COEF_BL   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COEF_BR   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_W   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_H   = 3'd5;

  localparam logic signed [CoefW-1:0] COEF_RESET = 16'sd4096;
  localparam logic [SizeW-1:0]        SIZE_RESET = 11'd64;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic signed [FiltW-1:0] filtered;
    logic                    window_full;
    logic                    frame_last;
  } result_t;

  typedef struct packed {
    logic [PixW-1:0] upper_left;
    logic [PixW-1:0] upper_right;
    logic [PixW-1:0] lower_left;
    logic [PixW-1:0] lower_right;
    logic            full;
    logic            last;
  } window_t;

  typedef struct packed {
    logic signed [CoefW-1:0] top_left;
    logic signed [CoefW-1:0] top_right;
    logic signed [CoefW-1:0] bottom_left;
    logic signed [CoefW-1:0] bottom_right;
  } coef_set_t;

endpackage

// ----- rtl/image_conv_2x2_filter.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    in_data_i   (pixel_in_t)
// out      output     out_valid_o / out_ready_i  out_data_o  (result_t)
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One pixel is accepted per clock unless the window path stalls; the line
// store has one read and one write per pixel, both taken at acceptance.
// Results pass the front stage, queue, product register and output register.
// Configuration writes are accepted in every cycle.
// Reset clears the counters, the upper-left and left neighbor pixels and all
// valid flags; the line store is not cleared.
// A two-entry queue between the front and the multiply stages lets each side
// stall on its own while the other keeps moving.

module image_conv_2x2_filter #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  icf_pkg::pixel_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output icf_pkg::result_t             out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [icf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [icf_pkg::CfgDataW-1:0] cfg_data_i
);
  import icf_pkg::*;

  coef_set_t        coef_q;
  logic [SizeW-1:0] frame_width_q, frame_height_q;
  logic             cfg_write;
  logic             fw_valid, fw_ready;
  window_t          fw_data;
  logic             bk_valid, bk_ready;
  window_t          bk_data;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.top_left     <= COEF_RESET;
      coef_q.top_right    <= COEF_RESET;
      coef_q.bottom_left  <= COEF_RESET;
      coef_q.bottom_right <= COEF_RESET;
      frame_width_q       <= SIZE_RESET;
      frame_height_q      <= SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_COEF_TL: coef_q.top_left     <= cfg_data_i;
        CFG_COEF_TR: coef_q.top_right    <= cfg_data_i;
        CFG_COEF_BL: coef_q.bottom_left  <= cfg_data_i;
        CFG_COEF_BR: coef_q.bottom_right <= cfg_data_i;
        CFG_FRAME_W: frame_width_q       <= cfg_data_i[SizeW-1:0];
        CFG_FRAME_H: frame_height_q      <= cfg_data_i[SizeW-1:0];
        default: begin
        end
      endcase
    end
  end

  icf_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .win_valid_o   (fw_valid),
    .win_ready_i   (fw_ready),
    .win_o         (fw_data)
  );

  icf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fw_valid),
    .push_ready_o(fw_ready),
    .push_data_i (fw_data),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_data_o  (bk_data)
  );

  icf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_i     (coef_q),
    .win_valid_i(bk_valid),
    .win_ready_o(bk_ready),
    .win_i      (bk_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- rtl/icf_front.sv -----
`timescale 1ns / 1ps

module icf_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [icf_pkg::SizeW-1:0] frame_width_i,
  input  logic [icf_pkg::SizeW-1:0] frame_height_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  icf_pkg::pixel_in_t        in_data_i,
  output logic                      win_valid_o,
  input  logic                      win_ready_i,
  output icf_pkg::window_t          win_o
);
  import icf_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);

  logic [PixW-1:0] line_mem [MAX_WIDTH];

  logic [ColW-1:0] col_q, col_d, eff_col, last_col;
  logic [RowW-1:0] row_q, row_d, eff_row, last_row;
  logic            s1_valid_q, s1_valid_d;
  logic [PixW-1:0] s1_px_q;
  logic            s1_full_q;
  logic            s1_last_q;
  logic [PixW-1:0] above_q;
  logic [PixW-1:0] ul_q;
  logic [PixW-1:0] left_q;
  logic            accept;
  logic            push;

  always_comb begin
    if ({21'd0, frame_width_i} > 32'(MAX_WIDTH)) begin
      last_col = ColW'(MAX_WIDTH - 1);
    end else if (frame_width_i < 11'd2) begin
      last_col = ColW'(1);
    end else begin
      last_col = ColW'(frame_width_i - 11'd1);
    end
    if ({21'd0, frame_height_i} > 32'(HeightLimit)) begin
      last_row = RowW'(HeightLimit - 1);
    end else if (frame_height_i < 11'd2) begin
      last_row = RowW'(1);
    end else begin
      last_row = RowW'(frame_height_i - 11'd1);
    end
  end

  assign eff_col = in_data_i.frame_start ? '0 : col_q;
  assign eff_row = in_data_i.frame_start ? '0 : row_q;

  assign push       = s1_valid_q && win_ready_i;
  assign in_ready_o = !s1_valid_q || push;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (eff_col >= last_col) begin
        col_d = '0;
        row_d = (eff_row >= last_row) ? '0 : eff_row + 1'b1;
      end else begin
        col_d = eff_col + 1'b1;
        row_d = eff_row;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      ul_q       <= '0;
      left_q     <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (push) begin
        ul_q   <= above_q;
        left_q <= s1_px_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      above_q           <= line_mem[eff_col];
      line_mem[eff_col] <= in_data_i.pixel;
      s1_px_q           <= in_data_i.pixel;
      s1_full_q         <= (eff_row != '0) && (eff_col != '0);
      s1_last_q         <= (eff_row == last_row) && (eff_col == last_col);
    end
  end

  assign win_valid_o       = s1_valid_q;
  assign win_o.upper_left  = ul_q;
  assign win_o.upper_right = above_q;
  assign win_o.lower_left  = left_q;
  assign win_o.lower_right = s1_px_q;
  assign win_o.full        = s1_full_q;
  assign win_o.last        = s1_last_q;

  // A pixel that opens a frame never has a full window.
  a_start_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.frame_start |=> s1_valid_q && !s1_full_q)
    else $error("frame start pixel marked as full window");

endmodule

// ----- rtl/icf_queue.sv -----
`timescale 1ns / 1ps

module icf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  icf_pkg::window_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output icf_pkg::window_t pop_data_o
);
  import icf_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  window_t         slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = count_q < CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CntW'(Depth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/icf_back.sv -----
`timescale 1ns / 1ps

module icf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  icf_pkg::coef_set_t coef_i,
  input  logic               win_valid_i,
  output logic               win_ready_o,
  input  icf_pkg::window_t   win_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output icf_pkg::result_t   out_data_o
);
  import icf_pkg::*;

  logic signed [ProdW-1:0] prod_d [4];
  logic signed [ProdW-1:0] prod_q [4];
  logic                    b1_valid_q, b1_full_q, b1_last_q;
  logic                    b1_ready, b2_ready;
  logic                    b1_load, b2_load;
  logic signed [FiltW-1:0] sum;
  logic                    out_valid_q;
  result_t                 out_q;

  assign b2_ready    = !out_valid_q || out_ready_i;
  assign b1_ready    = !b1_valid_q || b2_ready;
  assign win_ready_o = b1_ready;
  assign b1_load     = win_valid_i && b1_ready;
  assign b2_load     = b1_valid_q && b2_ready;

  always_comb begin
    prod_d[0] = coef_i.top_left     * $signed({1'b0, win_i.upper_left});
    prod_d[1] = coef_i.top_right    * $signed({1'b0, win_i.upper_right});
    prod_d[2] = coef_i.bottom_left  * $signed({1'b0, win_i.lower_left});
    prod_d[3] = coef_i.bottom_right * $signed({1'b0, win_i.lower_right});
    if (!win_i.full) begin
      for (int i = 0; i < 4; i++) begin
        prod_d[i] = '0;
      end
    end
  end

  assign sum = prod_q[0] + prod_q[1] + prod_q[2] + prod_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_valid_q <= win_valid_i;
      end
      if (b2_ready) begin
        out_valid_q <= b1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_load) begin
      prod_q    <= prod_d;
      b1_full_q <= win_i.full;
      b1_last_q <= win_i.last;
    end
    if (b2_load) begin
      out_q.filtered    <= sum;
      out_q.window_full <= b1_full_q;
      out_q.frame_last  <= b1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Without a full window the result must be zero.
  a_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.window_full |-> out_q.filtered == '0)
    else $error("nonzero result without full window");

endmodule
